// ===== design/ryc_pkg.sv =====
package ryc_pkg;

	// One pixel of three 8-bit components, first component in the low bits.
	typedef struct packed {
		logic [7:0] c;
		logic [7:0] b;
		logic [7:0] a;
	} pix_t;

	// Conversion direction codes.
	typedef enum logic {
		DIR_RGB_TO_YCC = 1'b0,
		DIR_YCC_TO_RGB = 1'b1
	} dir_t;

	// Weights in thousandths.
	localparam int W_257  = 257;
	localparam int W_504  = 504;
	localparam int W_98   = 98;
	localparam int W_148  = 148;
	localparam int W_291  = 291;
	localparam int W_439  = 439;
	localparam int W_368  = 368;
	localparam int W_71   = 71;
	localparam int W_1164 = 1164;
	localparam int W_1596 = 1596;
	localparam int W_391  = 391;
	localparam int W_814  = 814;
	localparam int W_2    = 2;
	localparam int W_2018 = 2018;
	localparam int W_1    = 1;

	// Offsets of studio-range YCbCr.
	localparam int LUMA_OFS   = 16;
	localparam int CHROMA_OFS = 128;

endpackage

// ===== design/ryc_matrix.sv =====
module ryc_matrix import ryc_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  dir_t direction,
	input  pix_t pix_in,
	output pix_t pix_out
);

	// Weights are below 2.1, operands 9-bit signed, three terms summed.
	localparam int SW = FRAC_BITS + 14;

	localparam int ONE = 1 << FRAC_BITS;

	localparam logic signed [SW-1:0] K_257  = SW'((W_257  * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_504  = SW'((W_504  * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_98   = SW'((W_98   * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_148  = SW'((W_148  * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_291  = SW'((W_291  * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_439  = SW'((W_439  * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_368  = SW'((W_368  * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_71   = SW'((W_71   * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_1164 = SW'((W_1164 * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_1596 = SW'((W_1596 * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_391  = SW'((W_391  * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_814  = SW'((W_814  * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_2    = SW'((W_2    * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_2018 = SW'((W_2018 * ONE + 500) / 1000);
	localparam logic signed [SW-1:0] K_1    = SW'((W_1    * ONE + 500) / 1000);

	localparam logic signed [SW-1:0] PIX_TOP = SW'(255) <<< FRAC_BITS;

	// Drop fraction bits, truncating toward zero.
	function automatic logic signed [SW-1:0] trunc_frac(input logic signed [SW-1:0] s);
		logic [SW-1:0] mag;
		begin
			mag = s[SW-1] ? SW'(-s) : SW'(s);
			mag = mag >> FRAC_BITS;
			trunc_frac = s[SW-1] ? -$signed(mag) : $signed(mag);
		end
	endfunction

	function automatic logic [7:0] sat8(input logic signed [SW-1:0] v);
		begin
			if (v < 0)
				sat8 = 8'd0;
			else if (v > SW'(255))
				sat8 = 8'd255;
			else
				sat8 = v[7:0];
		end
	endfunction

	// Clamp the fixed-point sum to 0..255 before dropping fractions.
	function automatic logic [7:0] clamp_pix(input logic signed [SW-1:0] s);
		logic [SW-1:0] sh;
		begin
			sh = SW'(s) >> FRAC_BITS;
			if (s < 0)
				clamp_pix = 8'd0;
			else if (s > PIX_TOP)
				clamp_pix = 8'd255;
			else
				clamp_pix = sh[7:0];
		end
	endfunction

	logic signed [SW-1:0] op_a;
	logic signed [SW-1:0] op_b;
	logic signed [SW-1:0] op_c;
	logic signed [SW-1:0] sum_a;
	logic signed [SW-1:0] sum_b;
	logic signed [SW-1:0] sum_c;

	always_comb begin
		// Forward uses the raw components, reverse removes the offsets first.
		if (direction == DIR_RGB_TO_YCC) begin
			op_a = $signed(SW'(pix_in.a));
			op_b = $signed(SW'(pix_in.b));
			op_c = $signed(SW'(pix_in.c));
		end else begin
			op_a = $signed(SW'(pix_in.a)) - SW'(LUMA_OFS);
			op_b = $signed(SW'(pix_in.b)) - SW'(CHROMA_OFS);
			op_c = $signed(SW'(pix_in.c)) - SW'(CHROMA_OFS);
		end

		if (direction == DIR_RGB_TO_YCC) begin
			sum_a =  K_257 * op_a + K_504 * op_b + K_98  * op_c;
			sum_b = -K_148 * op_a - K_291 * op_b + K_439 * op_c;
			sum_c =  K_439 * op_a - K_368 * op_b - K_71  * op_c;
			pix_out.a = sat8(trunc_frac(sum_a) + SW'(LUMA_OFS));
			pix_out.b = sat8(trunc_frac(sum_b) + SW'(CHROMA_OFS));
			pix_out.c = sat8(trunc_frac(sum_c) + SW'(CHROMA_OFS));
		end else begin
			sum_a = K_1164 * op_a - K_2    * op_b + K_1596 * op_c;
			sum_b = K_1164 * op_a - K_391  * op_b - K_814  * op_c;
			sum_c = K_1164 * op_a + K_2018 * op_b - K_1    * op_c;
			pix_out.a = clamp_pix(sum_a);
			pix_out.b = clamp_pix(sum_b);
			pix_out.c = clamp_pix(sum_c);
		end
	end

endmodule

// ===== design/rgb_ycbcr_color_converter.sv =====
// RGB <-> studio-range YCbCr (BT.601 weights) pixel converter. Each request on
// the slave stream carries one 8-bit three-component pixel and yields exactly
// one pixel on the master stream. cfg_wr_data selects the direction: 0 turns
// R,G,B into Y,Cb,Cr, 1 turns Y,Cb,Cr into R,G,B; write it only while no
// pixel is in flight. Weights are signed fixed point with COEF_FRAC_BITS
// fraction bits; results saturate to 0..255. Throughput is one pixel per
// clock while m_tready holds high. The accepting edge loads the input register
// and a later edge loads the output register, and m_tvalid, through the
// weighted-sum matrix. While a result waits the input register takes at
// most one more pixel, then s_tready drops until m_tready returns.
module rgb_ycbcr_color_converter import ryc_pkg::*; #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,   // direction

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,       // comp_a [7:0], comp_b [15:8], comp_c [23:16]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata        // out_a [7:0], out_b [15:8], out_c [23:16]
);

	dir_t direction_q;

	logic vld_s1;
	pix_t pix_s1;
	logic vld_s2;
	pix_t pix_s2;

	pix_t pix_conv;

	logic adv_s2;
	logic adv_s1;

	// Stage 2 loads when its slot is empty or its result leaves this cycle;
	// stage 1 loads when it is empty or moves into stage 2.
	assign adv_s2   = !vld_s2 || m_tready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign s_tready = adv_s1;

	assign m_tvalid = vld_s2;
	assign m_tdata  = pix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_RGB_TO_YCC;
		end else if (cfg_wr_en) begin
			direction_q <= dir_t'(cfg_wr_data);
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			pix_s1 <= pix_t'(s_tdata);
		end
	end

	ryc_matrix #(
		.FRAC_BITS (COEF_FRAC_BITS)
	) u_matrix (
		.direction (direction_q),
		.pix_in    (pix_s1),
		.pix_out   (pix_conv)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			pix_s2 <= pix_conv;
		end
	end

endmodule
